### rtl/pdcm_pkg.sv
package pdcm_pkg;

	localparam int CNT_W    = 16;
	localparam int PCT_W    = 7;
	localparam int CH_W     = 2;
	localparam int LVL_W    = 4;
	localparam int DEN_W    = CNT_W + 1;
	localparam int REM_W    = CNT_W + PCT_W;
	localparam int STEP_W   = 3;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam int unsigned DEFAULT_NUM_CHANNELS = 4;

	localparam logic [CNT_W-1:0]  TIMEOUT_RESET = 16'h0fff;
	localparam logic [PCT_W-1:0]  PERCENT_SCALE = 7'd100;
	localparam logic [STEP_W-1:0] DIV_FIRST_BIT = STEP_W'(PCT_W - 1);

	localparam logic REG_TIMEOUT_LIMIT = 1'b0;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_TIMEOUT = 1'b1;

	localparam logic [1:0] HI_SEL_ZERO = 2'd0;
	localparam logic [1:0] HI_SEL_HIGH = 2'd1;
	localparam logic [1:0] HI_SEL_CNT  = 2'd2;

	typedef struct packed {
		logic             cmd;
		logic [CH_W-1:0]  channel;
		logic [LVL_W-1:0] levels;
	} req_t;

	typedef struct packed {
		logic             status;
		logic [CH_W-1:0]  measured_channel;
		logic [CNT_W-1:0] high_ticks;
		logic [CNT_W-1:0] low_ticks;
		logic [PCT_W-1:0] high_percent;
		logic [PCT_W-1:0] low_percent;
	} rsp_t;

	typedef struct packed {
		logic       start;
		logic       step;
		logic       restart;
		logic       latch_high;
		logic       emit_timeout;
		logic [1:0] hi_sel;
		logic       div_go;
		logic       div_step;
		logic       div_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic lvl;
		logic ch_ok;
		logic cnt_hit;
		logic limit_zero;
		logic div_last;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/pdcm_ctrl.sv
module pdcm_ctrl
	import pdcm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_cmd,
	output logic       req_ready,
	input  dp_status_t st,
	output ctl_cmd_t   ctl
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WH   = 3'd1;
	localparam logic [2:0] ST_WL   = 3'd2;
	localparam logic [2:0] ST_CH   = 3'd3;
	localparam logic [2:0] ST_CL   = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] next_phase;
	logic       accept;
	logic       hold_lvl;
	logic       ends;
	logic       hit;

	assign req_ready = (state_q != ST_DIV) && (state_q != ST_OUT) && st.out_free;
	assign accept    = req_valid && req_ready;

	always_comb begin
		ctl        = '0;
		ctl.hi_sel = HI_SEL_ZERO;
		state_d    = state_q;
		hold_lvl   = (state_q == ST_WH) || (state_q == ST_CH);
		ends       = st.lvl != hold_lvl;
		next_phase = ends ? 3'(state_q + 3'd1) : state_q;
		hit        = ends ? st.limit_zero : st.cnt_hit;
		case (state_q)
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (st.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (st.out_free) begin
					ctl.div_out = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				if (accept && req_cmd == CMD_START) begin
					if (st.ch_ok) begin
						ctl.start = 1'b1;
						state_d   = ST_WH;
					end
				end else if (accept && (state_q inside {[ST_WH:ST_CL]})) begin
					if (ends && state_q == ST_CL) begin
						ctl.div_go = 1'b1;
						state_d    = ST_DIV;
					end else if (hit) begin
						ctl.emit_timeout = 1'b1;
						if (next_phase == ST_CL) begin
							ctl.hi_sel = ends ? HI_SEL_CNT : HI_SEL_HIGH;
						end
						state_d = ST_IDLE;
					end else begin
						ctl.step       = 1'b1;
						ctl.restart    = ends;
						ctl.latch_high = ends && state_q == ST_CH;
						state_d        = next_phase;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_no_req_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_OUT) |-> !req_ready)
		else $error("request taken while dividing");

	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_cmd == CMD_START && st.ch_ok) |=> state_q == ST_WH)
		else $error("start did not arm measurement");

	a_div_leads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && st.div_last) |=> state_q == ST_OUT)
		else $error("divider end lost");

endmodule

### rtl/pdcm_dp.sv
module pdcm_dp
	import pdcm_pkg::*;
#(
	parameter int unsigned NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  req_t             req,
	input  logic [CNT_W-1:0] limit,
	input  ctl_cmd_t         ctl,
	output dp_status_t       st,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp
);

	logic [CH_W-1:0]   active_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  high_q;
	logic [REM_W-1:0]  rem_h_q;
	logic [REM_W-1:0]  rem_l_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] k_q;
	logic [PCT_W-1:0]  qh_q;
	logic [PCT_W-1:0]  ql_q;
	logic              out_valid_q;
	rsp_t              out_q;
	logic [REM_W-1:0]  den_sh;
	logic              ge_h;
	logic              ge_l;
	logic [CNT_W-1:0]  to_hi;

	assign den_sh = REM_W'(den_q) << k_q;
	assign ge_h   = rem_h_q >= den_sh;
	assign ge_l   = rem_l_q >= den_sh;

	assign st.lvl        = req.levels[active_q];
	assign st.ch_ok      = 32'(req.channel) < NUM_CHANNELS;
	assign st.cnt_hit    = cnt_q >= limit;
	assign st.limit_zero = limit == '0;
	assign st.div_last   = k_q == '0;
	assign st.out_free   = !out_valid_q || rsp_ready;

	always_comb begin
		case (ctl.hi_sel)
			HI_SEL_HIGH: to_hi = high_q;
			HI_SEL_CNT:  to_hi = cnt_q;
			default:     to_hi = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			cnt_q    <= '0;
			high_q   <= '0;
			k_q      <= '0;
		end else begin
			if (ctl.start) begin
				active_q <= req.channel;
				cnt_q    <= '0;
				high_q   <= '0;
			end else begin
				if (ctl.step) begin
					cnt_q <= (ctl.restart ? '0 : cnt_q) + CNT_W'(1);
				end
				if (ctl.latch_high) begin
					high_q <= cnt_q;
				end
			end
			if (ctl.div_go) begin
				k_q <= DIV_FIRST_BIT;
			end else if (ctl.div_step && k_q != '0) begin
				k_q <= k_q - STEP_W'(1);
			end
		end
	end

	// restoring divide, one quotient bit per cycle, msb first
	always_ff @(posedge clk) begin
		if (ctl.div_go) begin
			rem_h_q <= REM_W'(high_q) * REM_W'(PERCENT_SCALE);
			rem_l_q <= REM_W'(cnt_q) * REM_W'(PERCENT_SCALE);
			den_q   <= DEN_W'(high_q) + DEN_W'(cnt_q);
			qh_q    <= '0;
			ql_q    <= '0;
		end else if (ctl.div_step) begin
			if (ge_h) begin
				rem_h_q <= rem_h_q - den_sh;
			end
			if (ge_l) begin
				rem_l_q <= rem_l_q - den_sh;
			end
			qh_q <= {qh_q[PCT_W-2:0], ge_h};
			ql_q <= {ql_q[PCT_W-2:0], ge_l};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit_timeout || ctl.div_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_timeout) begin
			out_q.status           <= STATUS_TIMEOUT;
			out_q.measured_channel <= active_q;
			out_q.high_ticks       <= to_hi;
			out_q.low_ticks        <= '0;
			out_q.high_percent     <= '0;
			out_q.low_percent      <= '0;
		end else if (ctl.div_out) begin
			out_q.status           <= STATUS_OK;
			out_q.measured_channel <= active_q;
			out_q.high_ticks       <= high_q;
			out_q.low_ticks        <= cnt_q;
			out_q.high_percent     <= qh_q;
			out_q.low_percent      <= ql_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_pct_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == STATUS_OK) |->
		((8'(out_q.high_percent) + 8'(out_q.low_percent)) == 8'd100 ||
		 (8'(out_q.high_percent) + 8'(out_q.low_percent)) == 8'd99))
		else $error("percentages do not add up");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == STATUS_TIMEOUT) |->
		(out_q.low_ticks == '0 && out_q.high_percent == '0 && out_q.low_percent == '0))
		else $error("timeout result carries counts");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit_timeout || ctl.div_out) |-> (!out_valid_q || rsp_ready))
		else $error("result register overwritten");

endmodule

### rtl/pulse_duty_cycle_meter.sv
// pulse duty-cycle meter
// request channel (req_valid/req_ready/req): a start request picks a channel and
// arms the measurement; tick requests carry all channel levels, one sample each.
// while measuring, one tick is taken per cycle unless requests are held off (see
// below): the phase logic decides each sample in the cycle it is accepted.
// response channel (rsp_valid/rsp_ready/rsp): one result per finished measurement.
// a timeout result is registered at the edge that accepts the failing tick.
// a good result goes through a 7-step restoring divider (one quotient bit per
// cycle for both percentages) and is then written to the output register;
// requests are held off while it divides and until that result is written.
// a waiting result sits in the output register; requests keep flowing while
// rsp_ready is high, and outside the divide are held off only while that register stays full.
// apb port: register 0 at byte address 0 is timeout_limit (16 bits, reset 4095).
// reset clears the measurement to idle, the output register to empty and the
// limit to 4095.
module pulse_duty_cycle_meter
	import pdcm_pkg::*;
#(
	parameter int unsigned NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [CNT_W-1:0] limit_q;
	logic             reg_sel;
	ctl_cmd_t         ctl;
	dp_status_t       st;

	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_W-1] == REG_TIMEOUT_LIMIT;
	assign prdata  = reg_sel ? DATA_W'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			limit_q <= pwdata[CNT_W-1:0];
		end
	end

	pdcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_ready (req_ready),
		.st        (st),
		.ctl       (ctl)
	);

	pdcm_dp #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.limit     (limit_q),
		.ctl       (ctl),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

### verif/pulse_duty_cycle_meter_tb.sv
module pulse_duty_cycle_meter_tb;
	import pdcm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int REQ_W        = $bits(req_t);

	typedef enum logic [2:0] {
		MEAS_IDLE,
		MEAS_WAIT_HIGH_END,
		MEAS_WAIT_LOW_END,
		MEAS_COUNT_HIGH,
		MEAS_COUNT_LOW
	} meas_phase_t;

	class duty_scoreboard;
		logic [CNT_W-1:0] limit;
		meas_phase_t      phase;
		logic [CH_W-1:0]  chan;
		int unsigned      phase_cnt;
		int unsigned      high_cnt;
		rsp_t             expected_q[$];
		int               errors;

		function new();
			limit     = TIMEOUT_RESET;
			phase     = MEAS_IDLE;
			chan      = '0;
			phase_cnt = 0;
			high_cnt  = 0;
			errors    = 0;
		endfunction

		function bit busy();
			return phase != MEAS_IDLE;
		endfunction

		function void push_result(logic st, int unsigned hi, int unsigned lo);
			rsp_t r;
			r.status           = st;
			r.measured_channel = chan;
			r.high_ticks       = CNT_W'(hi);
			r.low_ticks        = CNT_W'(lo);
			r.high_percent     = '0;
			r.low_percent      = '0;
			if (st == STATUS_OK) begin
				r.high_percent = PCT_W'(hi * int'(PERCENT_SCALE) / (hi + lo));
				r.low_percent  = PCT_W'(lo * int'(PERCENT_SCALE) / (hi + lo));
			end
			expected_q.push_back(r);
		endfunction

		function void note_request(req_t r);
			logic lvl;
			logic hold;
			if (r.cmd == CMD_START) begin
				if (r.channel < DEFAULT_NUM_CHANNELS) begin
					chan      = r.channel;
					phase     = MEAS_WAIT_HIGH_END;
					phase_cnt = 0;
					high_cnt  = 0;
				end
				return;
			end
			if (phase == MEAS_IDLE)
				return;
			lvl  = r.levels[chan];
			hold = (phase == MEAS_WAIT_HIGH_END || phase == MEAS_COUNT_HIGH);
			if (lvl != hold) begin
				// the edge sample opens the next phase
				case (phase)
					MEAS_COUNT_LOW: begin
						push_result(STATUS_OK, high_cnt, phase_cnt);
						phase     = MEAS_IDLE;
						phase_cnt = 0;
						return;
					end
					MEAS_COUNT_HIGH: begin
						high_cnt = phase_cnt;
						phase    = MEAS_COUNT_LOW;
					end
					MEAS_WAIT_LOW_END: phase = MEAS_COUNT_HIGH;
					default: phase = MEAS_WAIT_LOW_END;
				endcase
				phase_cnt = 0;
			end
			if (phase_cnt >= limit) begin
				push_result(STATUS_TIMEOUT, (phase == MEAS_COUNT_LOW) ? high_cnt : 0, 0);
				phase     = MEAS_IDLE;
				phase_cnt = 0;
				return;
			end
			phase_cnt = (phase_cnt + 1) & 32'h0000_ffff;
		endfunction

		function void check_field(string name, int unsigned exp, int unsigned act);
			if (exp != act) begin
				$error("%s: expected %0d, actual %0d", name, exp, act);
				errors++;
			end
		endfunction

		function void check_result(rsp_t r);
			rsp_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result: status %0d channel %0d", r.status,
					r.measured_channel);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			check_field("status", e.status, r.status);
			check_field("measured_channel", e.measured_channel, r.measured_channel);
			check_field("high_ticks", e.high_ticks, r.high_ticks);
			check_field("low_ticks", e.low_ticks, r.low_ticks);
			check_field("high_percent", e.high_percent, r.high_percent);
			check_field("low_percent", e.low_percent, r.low_percent);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_ready;
	rsp_t              rsp;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	duty_scoreboard sb = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int items_sent     = 0;
	int cycle_cnt      = 0;

	pulse_duty_cycle_meter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result(rsp);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic req_t tick(logic [LVL_W-1:0] levels);
		req_t r;
		r         = REQ_W'($urandom);
		r.cmd     = CMD_TICK;
		r.levels  = levels;
		return r;
	endfunction

	function automatic req_t tick_on(logic [CH_W-1:0] ch, logic lvl);
		req_t r;
		r            = tick(LVL_W'($urandom));
		r.levels[ch] = lvl;
		return r;
	endfunction

	function automatic req_t start_req(logic [CH_W-1:0] ch);
		req_t r;
		r         = REQ_W'($urandom);
		r.cmd     = CMD_START;
		r.channel = ch;
		return r;
	endfunction

	task automatic send_request(req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
		items_sent++;
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
	endtask

	// run any open measurement to its end, then let the divider finish
	task automatic quiesce();
		logic lvl;
		while (sb.busy()) begin
			lvl = !(sb.phase == MEAS_WAIT_HIGH_END || sb.phase == MEAS_COUNT_HIGH);
			send_request(tick_on(sb.chan, lvl));
		end
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [CNT_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * int'(REG_TIMEOUT_LIMIT));
		pwdata  <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.limit = value;
	endtask

	function automatic int unsigned pick_run();
		int unsigned cap;
		if (sb.limit == 0)
			return 1;
		cap = (sb.limit < 12) ? sb.limit : 12;
		if (sb.limit <= 64 && $urandom_range(99) < 10)
			return $urandom_range(sb.limit, sb.limit + 1);
		return $urandom_range(1, cap);
	endfunction

	// high run, low run, counted high, counted low, closing rise
	task automatic random_measurement();
		logic [CH_W-1:0] ch;
		int unsigned     runs[4];
		int              cut;
		ch = CH_W'($urandom);
		send_request(start_req(ch));
		runs[0] = ($urandom_range(1) == 0) ? 0 : pick_run();
		for (int i = 1; i < 4; i++)
			runs[i] = pick_run();
		cut = ($urandom_range(99) < 15) ? $urandom_range(0, 3) : 4;
		for (int i = 0; i < cut; i++)
			for (int k = 0; k < runs[i]; k++)
				send_request(tick_on(ch, (i % 2) == 0));
		if (cut == 4)
			send_request(tick_on(ch, 1'b1));
	endtask

	task automatic noise();
		req_t r;
		repeat ($urandom_range(1, 4)) begin
			r = REQ_W'($urandom);
			send_request(r);
		end
	endtask

	task automatic run_phase(logic [CNT_W-1:0] value, int send_pct, int recv_pct, int n);
		int target;
		quiesce();
		write_limit(value);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		target = items_sent + n;
		while (items_sent < target) begin
			if ($urandom_range(99) < 80)
				random_measurement();
			else
				noise();
			if ($urandom_range(99) < 4)
				drain_results();
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick while idle, then a full period on channel 3 at the reset limit
		send_request(tick(4'hf));
		send_request(start_req(2'd3));
		send_request(tick(4'hf));
		send_request(tick(4'h0));
		send_request(tick(4'hf));
		send_request(tick(4'hf));
		send_request(tick(4'h0));
		send_request(tick(4'h0));
		send_request(tick(4'h0));
		send_request(tick(4'hf));
		// restart mid-measurement
		send_request(start_req(2'd0));
		send_request(tick(4'he));
		send_request(start_req(2'd1));
		send_request(tick(4'hd));
		send_request(tick(4'h2));
		send_request(tick(4'hd));
		send_request(tick(4'h2));
		send_request(start_req(2'd2));
		send_request(tick(4'h0));
		send_request(tick(4'h4));
		send_request(tick(4'h0));
		send_request(tick(4'hb));
		send_request(tick(4'hf));
		drain_results();

		// zero limit fails on the first sample
		quiesce();
		write_limit(16'd0);
		send_request(start_req(2'd0));
		send_request(tick(4'hf));

		// timeout while waiting for the low run to end, then while counting low
		quiesce();
		write_limit(16'd2);
		send_request(start_req(2'd1));
		send_request(tick(4'h0));
		send_request(tick(4'h0));
		send_request(tick(4'h0));
		send_request(start_req(2'd2));
		send_request(tick(4'h0));
		send_request(tick(4'hf));
		send_request(tick(4'hf));
		send_request(tick(4'h0));
		send_request(tick(4'h0));
		send_request(tick(4'h0));

		run_phase(16'd5, 0, 0, 120);
		run_phase(16'd12, 71, 0, 120);
		run_phase(16'd1, 0, 71, 100);
		run_phase(16'd65535, 22, 22, 120);
		run_phase(16'd8, 22, 22, 100);
		run_phase(16'd0, 71, 0, 40);
		run_phase(16'd30, 0, 0, 80);
		run_phase(16'd3, 22, 22, 70);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			$error("%0d expected results never arrived", sb.expected_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
